// ===== hdl/oos_pkg.sv =====
package oos_pkg;

    // Fixed field and datapath widths (input bound is 21 bits, so the
    // sieving primes stay below 2^11 and the root table below 1024 entries).
    localparam int N_W        = 21;   // upper bound
    localparam int CNT_W      = 21;   // prime count
    localparam int SS_W       = 22;   // segment start / last value
    localparam int ROOT_DEPTH = 1024; // odd root entries, entry i is 2i+3
    localparam int RI_W       = 10;   // root table index
    localparam int RC_W       = 11;   // root count / root loop counter
    localparam int R_W        = 11;   // integer square root
    localparam int RB_W       = 4;    // square root bit position
    localparam int P_W        = 12;   // sieving prime
    localparam int PSQ_W      = 24;   // prime squared
    localparam int J_W        = 23;   // mark offset
    localparam int REM_W      = 13;   // remainder of segment start by p
    localparam int DIV_W      = 5;    // divider step counter
    localparam int TDATA_W    = 24;   // stream data width (byte padded)

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT_CLR,
        OP_LOAD,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_RCOUNT,
        OP_ROOT_CLR,
        OP_RS_READ,
        OP_I_INC,
        OP_SQ,
        OP_RS_JINIT,
        OP_RS_MARK,
        OP_SEG_INIT,
        OP_SEG_LEN,
        OP_J_FROM_SQ,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_J_FROM_REM,
        OP_SEG_MARK,
        OP_CNT_INIT,
        OP_CNT_STEP,
        OP_SEG_NEXT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic out_free;
        logic n_small;
        logic sqrt_last;
        logic clr_done;
        logic i_done;
        logic root_marked;
        logic rs_j_done;
        logic seg_past;
        logic psq_gt_last;
        logic psq_ge_start;
        logic div_last;
        logic seg_j_done;
        logic cnt_done;
    } status_t;

endpackage

// ===== hdl/odd_only_sieve_prime_count.sv =====
// Prime counter: odd-only segmented sieve.
//
// Input stream (s_*): one beat carries an upper bound n; the block answers
// with one beat on the output stream (m_*) holding the number of primes <= n,
// with 2 included. Bounds of 0 or 1 give 0; bounds above MAX_N are clamped.
//
// One beat is worked at a time. s_tready is high only while idle. The work is
// set by the one-bit mark memories, one access per cycle: a bitwise square
// root, a clear of each root entry, a sieve of the root table, then per
// segment a read of each root entry, at most one serial remainder per sieving
// prime, a write per marked multiple and a read per entry counted.
//
// Reset: aresetn is synchronous, active low. After its release the block
// sweeps the segment memory to zero, with s_tready low.
// Results sit in an output register; if m_tready stays low the finished
// count waits there and the block holds before loading the next one.
module odd_only_sieve_prime_count import oos_pkg::*; #(
    parameter int MAX_N        = 1048576,
    parameter int SEGMENT_SIZE = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [20:0] upper_bound, rest zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [20:0] prime_count, rest zero
);

    cmd_t             cmd;
    status_t          status;
    logic [CNT_W-1:0] prime_count;

    oos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    oos_dp #(
        .MAX_N        (MAX_N),
        .SEGMENT_SIZE (SEGMENT_SIZE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .upper_bound (s_tdata[N_W-1:0]),
        .prime_count (prime_count),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    // zero padding above the count
    assign m_tdata = TDATA_W'(prime_count);

    // an accepted beat starts work: no second beat the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second beat while working");

    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending beat");

    // a loaded result shows on the output next cycle
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |=> m_tvalid)
        else $error("result not presented");

endmodule

// ===== hdl/oos_dp.sv =====
module oos_dp import oos_pkg::*; #(
    parameter int MAX_N        = 1048576,
    parameter int SEGMENT_SIZE = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output status_t          status,
    input  logic [N_W-1:0]   upper_bound,
    output logic [CNT_W-1:0] prime_count,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int AW    = $clog2(SEGMENT_SIZE);
    localparam int LEN_W = $clog2(SEGMENT_SIZE + 1);
    localparam int MX_W  = $clog2(MAX_N + 1);
    localparam int CW    = (MX_W > N_W) ? MX_W : N_W;

    // memories
    logic seg_mem  [SEGMENT_SIZE];
    logic root_mem [ROOT_DEPTH];
    logic seg_rd_reg;
    logic root_rd_reg;

    // control registers
    logic             valid_reg;
    logic [LEN_W-1:0] k_reg;
    logic             pend_reg;

    // payload registers
    logic [N_W-1:0]   n_reg;
    logic [R_W-1:0]   r_reg;
    logic [RB_W-1:0]  rb_reg;
    logic [RC_W-1:0]  rcount_reg;
    logic [RC_W-1:0]  i_reg;
    logic [RC_W-1:0]  rk_reg;
    logic [P_W-1:0]   p_reg;
    logic [PSQ_W-1:0] psq_reg;
    logic [J_W-1:0]   j_reg;
    logic [SS_W-1:0]  ss_reg;
    logic [LEN_W-1:0] len_reg;
    logic [SS_W-1:0]  last_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SS_W-1:0]  dvd_reg;
    logic [DIV_W-1:0] dcnt_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] out_reg;

    // combinational datapath
    logic [CW-1:0]      ub_ext;
    logic [CW-1:0]      max_c;
    logic [N_W-1:0]     n_sat;
    logic [R_W-1:0]     trial;
    logic [2*R_W-1:0]   trial_sq;
    logic               sq_ok;
    logic [RC_W-1:0]    rcount_w;
    logic [P_W-1:0]     p_w;
    logic [PSQ_W-1:0]   psq_w;
    logic [SS_W-1:0]    diff_w;
    logic [SS_W-1:0]    half_w;
    logic [LEN_W-1:0]   len_w;
    logic [SS_W-1:0]    last_w;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   d0_w;
    logic [REM_W-1:0]   d1_w;
    logic               k_live;

    assign ub_ext   = CW'(upper_bound);
    assign max_c    = CW'(MAX_N);
    assign n_sat    = (ub_ext > max_c) ? N_W'(max_c) : upper_bound;

    assign trial    = r_reg | (R_W'(1) << rb_reg);
    assign trial_sq = trial * trial;
    assign sq_ok    = trial_sq <= (2*R_W)'(n_reg);

    assign rcount_w = (r_reg >= R_W'(3)) ? RC_W'(((r_reg - R_W'(3)) >> 1) + R_W'(1))
                                         : RC_W'(0);

    assign p_w      = P_W'({i_reg[RI_W-1:0], 1'b0}) + P_W'(3);
    assign psq_w    = PSQ_W'(p_w * p_w);

    // segment length is min((n - start)/2 + 1, SEGMENT_SIZE)
    assign diff_w   = SS_W'(n_reg) - ss_reg;
    assign half_w   = (diff_w >> 1) + SS_W'(1);
    assign len_w    = (half_w > SS_W'(SEGMENT_SIZE)) ? LEN_W'(SEGMENT_SIZE) : LEN_W'(half_w);
    assign last_w   = ss_reg + (SS_W'(len_w) << 1) - SS_W'(2);

    // restoring remainder, one dividend bit per step
    assign rem_sh   = {rem_reg[REM_W-2:0], dvd_reg[SS_W-1]};

    // first odd multiple at or above segment start, as an entry offset
    assign d0_w     = (rem_reg == '0) ? '0 : (REM_W'(p_reg) - rem_reg);
    assign d1_w     = d0_w[0] ? (d0_w + REM_W'(p_reg)) : d0_w;

    assign k_live   = k_reg < len_reg;

    // status
    assign status.init_last    = (k_reg == LEN_W'(SEGMENT_SIZE - 1));
    assign status.out_free     = !valid_reg || out_ready;
    assign status.n_small      = (n_reg < N_W'(2));
    assign status.sqrt_last    = (rb_reg == '0);
    assign status.clr_done     = (rk_reg >= rcount_reg);
    assign status.i_done       = (i_reg >= rcount_reg);
    assign status.root_marked  = root_rd_reg;
    assign status.rs_j_done    = (j_reg >= J_W'(rcount_reg));
    assign status.seg_past     = (ss_reg > SS_W'(n_reg));
    assign status.psq_gt_last  = (psq_reg > PSQ_W'(last_reg));
    assign status.psq_ge_start = (psq_reg >= PSQ_W'(ss_reg));
    assign status.div_last     = (dcnt_reg == '0);
    assign status.seg_j_done   = (j_reg >= J_W'(len_reg));
    assign status.cnt_done     = !k_live && !pend_reg;

    assign prime_count = out_reg;
    assign out_valid   = valid_reg;

    // segment mark memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        seg_rd_reg <= seg_mem[k_reg[AW-1:0]];
        if (cmd.op == OP_INIT_CLR) begin
            seg_mem[k_reg[AW-1:0]] <= 1'b0;
        end else if (cmd.op == OP_SEG_MARK) begin
            seg_mem[j_reg[AW-1:0]] <= 1'b1;
        end else if (cmd.op == OP_CNT_STEP && k_live) begin
            seg_mem[k_reg[AW-1:0]] <= 1'b0;  // read and clear
        end
    end

    // root mark memory
    always_ff @(posedge aclk) begin
        root_rd_reg <= root_mem[i_reg[RI_W-1:0]];
        if (cmd.op == OP_ROOT_CLR) begin
            root_mem[rk_reg[RI_W-1:0]] <= 1'b0;
        end else if (cmd.op == OP_RS_MARK) begin
            root_mem[j_reg[RI_W-1:0]] <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= (cmd.op == OP_CNT_STEP) && k_live;
            if (cmd.op == OP_EMIT) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
            if (cmd.op == OP_INIT_CLR) begin
                k_reg <= k_reg + LEN_W'(1);
            end else if (cmd.op == OP_CNT_INIT) begin
                k_reg <= '0;
            end else if (cmd.op == OP_CNT_STEP && k_live) begin
                k_reg <= k_reg + LEN_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pend_reg && !seg_rd_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        unique case (cmd.op)
            OP_LOAD: begin
                n_reg   <= n_sat;
                cnt_reg <= '0;
            end
            OP_SQRT_INIT: begin
                r_reg  <= '0;
                rb_reg <= RB_W'(R_W - 1);
            end
            OP_SQRT_STEP: begin
                if (sq_ok) begin
                    r_reg <= trial;
                end
                rb_reg <= rb_reg - RB_W'(1);
            end
            OP_RCOUNT: begin
                rcount_reg <= rcount_w;
                rk_reg     <= '0;
                i_reg      <= '0;
            end
            OP_ROOT_CLR: begin
                rk_reg <= rk_reg + RC_W'(1);
            end
            OP_I_INC: begin
                i_reg <= i_reg + RC_W'(1);
            end
            OP_SQ: begin
                p_reg   <= p_w;
                psq_reg <= psq_w;
            end
            OP_RS_JINIT: begin
                j_reg <= J_W'((psq_reg - PSQ_W'(3)) >> 1);
            end
            OP_RS_MARK, OP_SEG_MARK: begin
                j_reg <= j_reg + J_W'(p_reg);
            end
            OP_SEG_INIT: begin
                ss_reg  <= SS_W'(3);
                cnt_reg <= CNT_W'(1);       // the prime two
            end
            OP_SEG_LEN: begin
                len_reg  <= len_w;
                last_reg <= last_w;
                i_reg    <= '0;
            end
            OP_J_FROM_SQ: begin
                j_reg <= J_W'((psq_reg - PSQ_W'(ss_reg)) >> 1);
            end
            OP_DIV_INIT: begin
                rem_reg  <= '0;
                dvd_reg  <= ss_reg;
                dcnt_reg <= DIV_W'(SS_W - 1);
            end
            OP_DIV_STEP: begin
                rem_reg  <= (rem_sh >= REM_W'(p_reg)) ? (rem_sh - REM_W'(p_reg)) : rem_sh;
                dvd_reg  <= dvd_reg << 1;
                dcnt_reg <= dcnt_reg - DIV_W'(1);
            end
            OP_J_FROM_REM: begin
                j_reg <= J_W'(d1_w >> 1);
            end
            OP_SEG_NEXT: begin
                ss_reg <= ss_reg + SS_W'(2 * SEGMENT_SIZE);
            end
            OP_EMIT: begin
                out_reg <= cnt_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/oos_ctrl.sv =====
module oos_ctrl import oos_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CHECK, S_SQRT, S_RCNT, S_RCLR,
        S_RS_ADDR, S_RS_TEST, S_RS_JINIT, S_RS_MARK,
        S_SEG_INIT, S_SEG_TOP, S_SP_ADDR, S_SP_TEST, S_SP_CMP,
        S_SP_DIV, S_SP_OFF, S_SP_MARK, S_CNT_RUN, S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_INIT: begin
                cmd.op = OP_INIT_CLR;
                if (status.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.n_small) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SQRT_INIT;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.op = OP_SQRT_STEP;
                if (status.sqrt_last) state_next = S_RCNT;
            end
            S_RCNT: begin
                cmd.op     = OP_RCOUNT;
                state_next = S_RCLR;
            end
            S_RCLR: begin
                if (status.clr_done) state_next = S_RS_ADDR;
                else                 cmd.op     = OP_ROOT_CLR;
            end
            S_RS_ADDR: begin
                if (status.i_done) begin
                    state_next = S_SEG_INIT;
                end else begin
                    cmd.op     = OP_RS_READ;
                    state_next = S_RS_TEST;
                end
            end
            S_RS_TEST: begin
                if (status.root_marked) begin
                    cmd.op     = OP_I_INC;
                    state_next = S_RS_ADDR;
                end else begin
                    cmd.op     = OP_SQ;
                    state_next = S_RS_JINIT;
                end
            end
            S_RS_JINIT: begin
                cmd.op     = OP_RS_JINIT;
                state_next = S_RS_MARK;
            end
            S_RS_MARK: begin
                if (status.rs_j_done) begin
                    cmd.op     = OP_I_INC;
                    state_next = S_RS_ADDR;
                end else begin
                    cmd.op = OP_RS_MARK;
                end
            end
            S_SEG_INIT: begin
                cmd.op     = OP_SEG_INIT;
                state_next = S_SEG_TOP;
            end
            S_SEG_TOP: begin
                if (status.seg_past) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SEG_LEN;
                    state_next = S_SP_ADDR;
                end
            end
            S_SP_ADDR: begin
                if (status.i_done) begin
                    cmd.op     = OP_CNT_INIT;
                    state_next = S_CNT_RUN;
                end else begin
                    cmd.op     = OP_RS_READ;
                    state_next = S_SP_TEST;
                end
            end
            S_SP_TEST: begin
                if (status.root_marked) begin
                    cmd.op     = OP_I_INC;
                    state_next = S_SP_ADDR;
                end else begin
                    cmd.op     = OP_SQ;
                    state_next = S_SP_CMP;
                end
            end
            S_SP_CMP: begin
                priority if (status.psq_gt_last) begin
                    cmd.op     = OP_CNT_INIT;
                    state_next = S_CNT_RUN;
                end else if (status.psq_ge_start) begin
                    cmd.op     = OP_J_FROM_SQ;
                    state_next = S_SP_MARK;
                end else begin
                    cmd.op     = OP_DIV_INIT;
                    state_next = S_SP_DIV;
                end
            end
            S_SP_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) state_next = S_SP_OFF;
            end
            S_SP_OFF: begin
                cmd.op     = OP_J_FROM_REM;
                state_next = S_SP_MARK;
            end
            S_SP_MARK: begin
                if (status.seg_j_done) begin
                    cmd.op     = OP_I_INC;
                    state_next = S_SP_ADDR;
                end else begin
                    cmd.op = OP_SEG_MARK;
                end
            end
            S_CNT_RUN: begin
                if (status.cnt_done) begin
                    cmd.op     = OP_SEG_NEXT;
                    state_next = S_SEG_TOP;
                end else begin
                    cmd.op = OP_CNT_STEP;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oos_pkg::*;

    // Bench sizing: matches the DUT defaults.
    localparam int MAX_BOUND    = 1048576;
    localparam int SEG_ENTRIES  = 4096;
    localparam int ODD_SLOTS    = MAX_BOUND / 2;   // slot k holds the odd number 2k+1
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BEATS = 76;
    localparam int MAX_WAIT     = 10;              // longest idle/stall per beat
    localparam int DRAIN_CYCLES = 64;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;     // [20:0] upper_bound, rest zero
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [TDATA_W-1:0] m_tdata;          // [20:0] prime_count, rest zero

    // Bounds waiting to be driven, and prime counts waiting to come back.
    logic [N_W-1:0]   bounds_to_send[$];
    logic [CNT_W-1:0] pending_counts[$];

    // Odd-only sieve of the whole range plus a running count of odd primes,
    // so that each prediction is one table lookup.
    bit odd_composite [ODD_SLOTS];
    int odd_prime_total [ODD_SLOTS];

    int error_count = 0;

    // Handshake flags seen at the last rising edge, read by the falling-edge drivers.
    logic in_beat_taken = 1'b0;
    logic out_beat_taken = 1'b0;

    int send_gap = 0;
    bit send_burst = 1'b0;
    int recv_stall = 0;
    bit recv_burst = 1'b0;

    odd_only_sieve_prime_count #(
        .MAX_N        (MAX_BOUND),
        .SEGMENT_SIZE (SEG_ENTRIES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic sieve_odd_table();
        int p;
        int m;
        int k;
        int running;
        for (p = 3; p * p <= MAX_BOUND; p += 2) begin
            if (!odd_composite[p / 2]) begin
                for (m = p * p; m < MAX_BOUND; m += 2 * p) odd_composite[m / 2] = 1'b1;
            end
        end
        // slot 0 is the number 1, which is not prime
        running = 0;
        for (k = 0; k < ODD_SLOTS; k++) begin
            if (k != 0 && !odd_composite[k]) running++;
            odd_prime_total[k] = running;
        end
    endtask

    // Primes <= bound, 2 included. Bounds past MAX_BOUND clamp; below two give 0.
    function automatic logic [CNT_W-1:0] prime_count_upto(logic [N_W-1:0] bound);
        int n;
        n = (bound > MAX_BOUND) ? MAX_BOUND : int'(bound);
        if (n < 2) return '0;
        // largest odd <= n sits in slot (n-1)/2; add one for the prime 2
        return CNT_W'(1 + odd_prime_total[(n - 1) / 2]);
    endfunction

    task automatic report_error(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        error_count++;
        $display("[%0t] ERROR %s: prime_count got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Input driver: changes at the falling edge. One NBA per signal per edge,
    // so back-to-back beats keep s_tvalid high without a glitch.
    always @(negedge aclk) begin : bound_driver
        logic               nxt_valid;
        logic [TDATA_W-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (aresetn) begin
            if (s_tvalid && in_beat_taken) begin
                nxt_valid = 1'b0;
                // occasional switch into/out of a no-gap burst
                if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (bounds_to_send.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = TDATA_W'(bounds_to_send.pop_front());
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // Result sink: the stall only counts down while a result is on offer,
    // so back-pressure really lands on the output register.
    always @(negedge aclk) begin : count_sink
        if (out_beat_taken) begin
            if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (m_tvalid && recv_stall != 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: everything sampled at the rising edge.
    always @(posedge aclk) begin : beat_monitor
        logic [CNT_W-1:0] want;
        if (!aresetn) begin
            in_beat_taken  <= 1'b0;
            out_beat_taken <= 1'b0;
        end else begin
            in_beat_taken  <= s_tvalid && s_tready;
            out_beat_taken <= m_tvalid && m_tready;
            // result side first: a beat leaving now belongs to an earlier request
            if (m_tvalid && m_tready) begin
                if (pending_counts.size() == 0) begin
                    report_error("unexpected beat", m_tdata[CNT_W-1:0], '0);
                end else begin
                    want = pending_counts.pop_front();
                    if (m_tdata[CNT_W-1:0] !== want)
                        report_error("count mismatch", m_tdata[CNT_W-1:0], want);
                    if (m_tdata[TDATA_W-1:CNT_W] !== '0)
                        report_error("nonzero tdata pad", m_tdata[CNT_W-1:0], want);
                end
            end
            if (s_tvalid && s_tready)
                pending_counts.push_back(prime_count_upto(s_tdata[N_W-1:0]));
        end
    end

    // Directed bounds:
    //   bound below two (0, 1), the smallest primes, odd squares of primes,
    //   ends of the first segment (8193 is its last odd, 8195 opens the next),
    //   the exact maximum and the all-ones bound that clamps to it.
    // Only the two largest run the full range.
    int unsigned directed_bounds [24] = '{
        0, 1, 2, 3, 4, 5, 7, 8, 9, 15, 25, 49, 120, 121, 169, 1023,
        8191, 8193, 8195, 8197, 16387, 65535, 1048576, 2097151
    };

    initial begin : stimulus
        int pick;
        sieve_odd_table();
        foreach (directed_bounds[i]) bounds_to_send.push_back(N_W'(directed_bounds[i]));
        // Random part: mostly single-segment bounds, some spanning a few
        // segments, kept small since cost grows with the bound.
        repeat (RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                bounds_to_send.push_back(N_W'($urandom_range(0, 600)));
            else if (pick < 9)
                bounds_to_send.push_back(N_W'($urandom_range(601, 8191)));
            else
                bounds_to_send.push_back(N_W'($urandom_range(8192, 40000)));
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // block sweeps its segment memory first; the driver just waits on s_tready
        while (bounds_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_counts.size() != 0) @(posedge aclk);
        // catch any stray extra result
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // The timeout covers the slowest legal run (two full-range requests plus
    // worst-case random bounds) with room to spare.
    initial begin : watchdog
        #300000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== odd_only_sieve_prime_count.f =====
hdl/oos_pkg.sv
hdl/oos_dp.sv
hdl/oos_ctrl.sv
hdl/odd_only_sieve_prime_count.sv
dv/tb_top.sv
